[rtl/max_drawdown_tracker_unit_assert.svh]
// Assertion macros shared by the drawdown tracker modules.
`ifndef MAX_DRAWDOWN_TRACKER_UNIT_ASSERT_SVH
`define MAX_DRAWDOWN_TRACKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MDT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define MDT_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MDT_ASSERT(label, clk, rst_n, prop)
`define MDT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/mdt_pkg.sv]
// Package: shared types and constants of the drawdown tracker.
package mdt_pkg;
	localparam int MaxDays = 65536;
	localparam logic [15:0] DayLimit = (MaxDays - 1 > 65535) ? 16'hFFFF : 16'(MaxDays - 1);
	localparam logic [47:0] ValMax = {48{1'b1}};
	localparam logic [47:0] OneQ32 = 48'h1_0000_0000;
	localparam logic [31:0] DdFull = 32'h8000_0000;

	// classified day handed from front to back
	typedef struct packed {
		logic        valid_day;
		logic        fin;
		logic [32:0] factor;   // 2^28 + r, signed
		logic [15:0] idx;
	} mdt_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_CMP, ST_DIV, ST_UPD, ST_OUT
	} mdt_state_t;
endpackage

[rtl/mdt_front.sv]
// Front end: accepts days, tracks gaps and day index, queues classified words.
`include "max_drawdown_tracker_unit_assert.svh"
module mdt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [31:0]      day_return,
	input  logic             missing,
	input  logic             last,
	output logic             cmd_valid,
	output mdt_pkg::mdt_cmd_t cmd,
	input  logic             cmd_take
);
	mdt_pkg::mdt_cmd_t fifo_q [2];
	logic [1:0]  cnt_q;
	logic        rd_q, wr_q;
	logic [15:0] day_q, gap_start_q;
	logic        gap_open_q;
	logic        acc;
	mdt_pkg::mdt_cmd_t nc;

	assign full = cnt_q == 2'd2;
	assign acc = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = fifo_q[rd_q];

	always_comb begin
		nc.valid_day = !missing;
		nc.fin = last;
		nc.factor = 33'sh1000_0000 + {{1{day_return[31]}}, day_return};
		nc.idx = gap_open_q ? gap_start_q : day_q;
	end

	always_ff @(posedge clk) begin
		if (acc) fifo_q[wr_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
			day_q <= '0; gap_start_q <= '0; gap_open_q <= 1'b0;
		end else begin
			if (acc) wr_q <= !wr_q;
			if (cmd_take && cmd_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take && cmd_valid);
			if (acc) begin
				if (last) begin
					day_q <= '0; gap_open_q <= 1'b0; gap_start_q <= '0;
				end else begin
					if (day_q < mdt_pkg::DayLimit) day_q <= day_q + 16'd1;
					if (missing && !gap_open_q) begin
						gap_open_q <= 1'b1; gap_start_q <= day_q;
					end else if (!missing) gap_open_q <= 1'b0;
				end
			end
		end
	end

	`MDT_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= 2'd2)
	`MDT_ASSERT(a_no_acc_full, clk, arst_n, full |-> !acc)
	`MDT_ASSERT(a_gap_le_day, clk, arst_n, gap_open_q |-> gap_start_q <= day_q)
endmodule

[rtl/mdt_back.sv]
// Back end: compounds value, divides drawdown, tracks trough and recovery.
`include "max_drawdown_tracker_unit_assert.svh"
module mdt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  mdt_pkg::mdt_cmd_t cmd,
	output logic             cmd_take,
	output logic             empty,
	input  logic             pop,
	output logic [31:0]      max_drawdown,
	output logic [15:0]      trough_day,
	output logic [15:0]      recovery_days,
	output logic             recovered,
	output logic             all_missing
);
	mdt_pkg::mdt_state_t st_q, st_d;
	mdt_pkg::mdt_cmd_t   c_q;
	logic [47:0] val_q, peak_q, nv_q, rem_q;
	logic [31:0] best_q, q_q;
	logic [15:0] trough_q, rcnt_q;
	logic        rfound_q, seen_q;
	logic [4:0]  it_q;
	logic [56:0] a_q, b_q;
	logic        out_v_q;
	logic [31:0] o_dd_q;
	logic [15:0] o_tr_q, o_rc_q;
	logic        o_rec_q, o_all_q;
	logic [48:0] r2;
	logic [53:0] res;
	logic [47:0] nv_d;

	assign empty = !out_v_q;
	assign max_drawdown = o_dd_q;
	assign trough_day = o_tr_q;
	assign recovery_days = o_rc_q;
	assign recovered = o_rec_q;
	assign all_missing = o_all_q;
	assign cmd_take = (st_q == mdt_pkg::ST_IDLE) && cmd_valid;
	assign r2 = {rem_q, 1'b0};
	assign res = 54'(a_q >> 4) + 54'((({53'd0, a_q[3:0]} << 24) + 57'(b_q)) >> 28);
	// clamp at zero for a non-positive factor, saturate at the top
	assign nv_d = (c_q.factor[32] || c_q.factor == 33'd0) ? 48'd0
		: (res > 54'(mdt_pkg::ValMax) ? mdt_pkg::ValMax : res[47:0]);

	always_comb begin
		st_d = st_q;
		case (st_q)
			mdt_pkg::ST_IDLE: if (cmd_valid) st_d = cmd.valid_day ? mdt_pkg::ST_MUL
				: (cmd.fin ? mdt_pkg::ST_OUT : mdt_pkg::ST_IDLE);
			mdt_pkg::ST_MUL: st_d = mdt_pkg::ST_CMP;
			mdt_pkg::ST_CMP: st_d = (nv_d >= peak_q || nv_d == 48'd0) ? mdt_pkg::ST_UPD
				: mdt_pkg::ST_DIV;
			mdt_pkg::ST_DIV: if (it_q == 5'd30) st_d = mdt_pkg::ST_UPD;
			mdt_pkg::ST_UPD: st_d = c_q.fin ? mdt_pkg::ST_OUT : mdt_pkg::ST_IDLE;
			mdt_pkg::ST_OUT: if (!out_v_q || pop) st_d = mdt_pkg::ST_IDLE;
			default: st_d = mdt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			mdt_pkg::ST_IDLE: if (cmd_valid) c_q <= cmd;
			mdt_pkg::ST_MUL: begin
				a_q <= 57'(val_q[47:24]) * 57'(c_q.factor[31:0]);
				b_q <= 57'(val_q[23:0]) * 57'(c_q.factor[31:0]);
			end
			mdt_pkg::ST_CMP: begin
				nv_q <= nv_d;
				it_q <= '0; q_q <= '0;
			end
			default: ;
		endcase
		if (st_q == mdt_pkg::ST_CMP) rem_q <= peak_q - nv_d;
		else if (st_q == mdt_pkg::ST_DIV) begin
			// one restoring step per cycle
			it_q <= it_q + 5'd1;
			if (r2 >= {1'b0, peak_q}) begin
				rem_q <= 48'(r2 - {1'b0, peak_q}); q_q <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= r2[47:0]; q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	logic [31:0] dd;
	always_comb begin
		if (peak_q == 48'd0 || nv_q >= peak_q) dd = '0;
		else if (nv_q == 48'd0) dd = mdt_pkg::DdFull;
		else dd = q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mdt_pkg::ST_IDLE;
			val_q <= mdt_pkg::OneQ32; peak_q <= '0; best_q <= '0; trough_q <= '0;
			rcnt_q <= '0; rfound_q <= 1'b0; seen_q <= 1'b0; out_v_q <= 1'b0;
			o_dd_q <= '0; o_tr_q <= '0; o_rc_q <= '0; o_rec_q <= 1'b0; o_all_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop && out_v_q) out_v_q <= 1'b0;
			if (st_q == mdt_pkg::ST_UPD) begin
				seen_q <= 1'b1;
				val_q <= nv_q;
				if (nv_q >= peak_q) begin
					if (best_q != 0 && !rfound_q && c_q.idx > trough_q) begin
						rfound_q <= 1'b1; rcnt_q <= c_q.idx - trough_q;
					end
					peak_q <= nv_q;
				end else if (dd > best_q) begin
					best_q <= dd; trough_q <= c_q.idx; rfound_q <= 1'b0; rcnt_q <= '0;
				end
			end
			if (st_q == mdt_pkg::ST_OUT && (!out_v_q || pop)) begin
				out_v_q <= 1'b1;
				o_all_q <= !seen_q;
				o_dd_q <= (seen_q && best_q != 0) ? best_q : '0;
				o_tr_q <= (seen_q && best_q != 0) ? trough_q : '0;
				o_rc_q <= (seen_q && best_q != 0 && rfound_q) ? rcnt_q : '0;
				o_rec_q <= seen_q && (best_q == 0 || rfound_q);
				val_q <= mdt_pkg::OneQ32; peak_q <= '0; best_q <= '0; trough_q <= '0;
				rcnt_q <= '0; rfound_q <= 1'b0; seen_q <= 1'b0;
			end
		end
	end

	`MDT_ASSERT(a_dd_max, clk, arst_n, best_q <= mdt_pkg::DdFull)
	`MDT_ASSERT(a_take_idle, clk, arst_n, cmd_take |-> st_q == mdt_pkg::ST_IDLE)
	`MDT_ASSERT(a_div_len, clk, arst_n, st_q == mdt_pkg::ST_DIV |-> it_q <= 5'd30)
endmodule

[rtl/max_drawdown_tracker_unit.sv]
// Top level of the maximum drawdown tracker.
// Each day is one input word; a valid day is multiplied, compared and updated,
// plus the 31-step serial divider in the back end if below the peak and nonzero.
// Missing days skip these steps. A two-entry queue between front and back lets
// input flow on while the back end works; one result word per series.
module max_drawdown_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] day_return,
	input  logic        missing,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] max_drawdown,
	output logic [15:0] trough_day,
	output logic [15:0] recovery_days,
	output logic        recovered,
	output logic        all_missing
);
	logic cmd_valid, cmd_take;
	mdt_pkg::mdt_cmd_t cmd;

	mdt_front u_front (.clk, .arst_n, .push, .full, .day_return, .missing, .last,
		.cmd_valid, .cmd, .cmd_take);
	mdt_back u_back (.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop,
		.max_drawdown, .trough_day, .recovery_days, .recovered, .all_missing);
endmodule

[tb/tb_max_drawdown_tracker_unit.sv]
// Testbench for the maximum drawdown tracker: directed and random series checked against a local predictor.
module tb_max_drawdown_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] ret;
		logic        miss;
		logic        fin;
	} day_word_t;

	typedef struct {
		logic [31:0] dd;
		logic [15:0] trough;
		logic [15:0] rec_days;
		logic        rec;
		logic        all_miss;
	} dd_report_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [31:0] day_return;
	logic        missing;
	logic        last;
	logic        empty;
	logic        pop;
	logic [31:0] max_drawdown;
	logic [15:0] trough_day;
	logic [15:0] recovery_days;
	logic        recovered;
	logic        all_missing;

	day_word_t  pending_days[$];
	dd_report_t expected_reports[$];
	int         fail_count = 0;
	int         cycle_count = 0;
	bit         stim_done = 0;
	int         hold_off = 0;
	int         push_gap = 0;
	int         stall_left;

	// predictor state
	logic [47:0] cum_val;
	logic [47:0] peak_val;
	logic [31:0] best_dd;
	logic [15:0] trough_idx;
	logic [15:0] rec_cnt;
	logic        rec_found;
	logic [15:0] day_cnt;
	logic [15:0] gap_idx;
	logic        in_gap;
	logic        any_valid;

	max_drawdown_tracker_unit i_dut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic clear_series();
		cum_val = mdt_pkg::OneQ32;
		peak_val = '0;
		best_dd = '0;
		trough_idx = '0;
		rec_cnt = '0;
		rec_found = 1'b0;
		day_cnt = '0;
		gap_idx = '0;
		in_gap = 1'b0;
		any_valid = 1'b0;
	endtask

	function automatic logic [47:0] grow(logic [47:0] v, logic signed [32:0] f);
		logic [81:0] prod;
		if (f <= 0)
			return '0;
		prod = ({34'd0, v} * {49'd0, f[32:0]}) >> 28;
		return (prod > {34'd0, mdt_pkg::ValMax}) ? mdt_pkg::ValMax : prod[47:0];
	endfunction

	function automatic logic [31:0] depth(logic [47:0] v, logic [47:0] pk);
		logic [79:0] num;
		if (pk == 0 || v >= pk)
			return '0;
		if (v == 0)
			return mdt_pkg::DdFull;
		num = {32'd0, pk - v} << 31;
		return 32'(num / {32'd0, pk});
	endfunction

	// apply one accepted day; queue a report on the last day
	task automatic predict_day(day_word_t d);
		logic signed [32:0] f;
		logic [47:0] v;
		logic [15:0] idx;
		logic [31:0] dd;
		dd_report_t rpt;
		if (d.miss) begin
			if (!in_gap) begin
				in_gap = 1'b1;
				gap_idx = day_cnt;
			end
		end else begin
			f = 33'sd268435456 + {{1{d.ret[31]}}, d.ret};
			idx = in_gap ? gap_idx : day_cnt;
			v = grow(cum_val, f);
			in_gap = 1'b0;
			any_valid = 1'b1;
			cum_val = v;
			if (v >= peak_val) begin
				if (best_dd != 0 && !rec_found && idx > trough_idx) begin
					rec_found = 1'b1;
					rec_cnt = idx - trough_idx;
				end
				peak_val = v;
			end else begin
				dd = depth(v, peak_val);
				if (dd > best_dd) begin
					best_dd = dd;
					trough_idx = idx;
					rec_found = 1'b0;
					rec_cnt = '0;
				end
			end
		end
		if (day_cnt < mdt_pkg::DayLimit)
			day_cnt++;
		if (d.fin) begin
			rpt = '{dd: '0, trough: '0, rec_days: '0, rec: 1'b0, all_miss: 1'b0};
			if (!any_valid)
				rpt.all_miss = 1'b1;
			else if (best_dd == 0)
				rpt.rec = 1'b1;
			else begin
				rpt.dd = best_dd;
				rpt.trough = trough_idx;
				rpt.rec_days = rec_found ? rec_cnt : '0;
				rpt.rec = rec_found;
			end
			expected_reports.push_back(rpt);
			clear_series();
		end
	endtask

	task automatic add_day(logic [31:0] r, logic m, logic f);
		pending_days.push_back('{ret: r, miss: m, fin: f});
	endtask

	function automatic logic [31:0] rand_return();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 32'($signed($urandom_range(0, 40000000)) - 20000000);
		if (p < 75)
			return 32'($signed($urandom_range(0, 200000000)) - 100000000);
		if (p < 85)
			return $urandom();
		if (p < 92)
			return 32'hF000_0000 - $urandom_range(0, 3);
		return 32'h7FFF_FFFF - $urandom_range(0, 3);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			day_return <= '0;
			missing <= 1'b0;
			last <= 1'b0;
			push_gap <= 0;
		end else begin
			if (push && !full) begin
				predict_day(pending_days.pop_front());
			end
			if (!(push && full)) begin
				if (push_gap > 0) begin
					push_gap <= push_gap - 1;
					push <= 1'b0;
				end else if (pending_days.size() > (push && !full ? 0 : 0)
					&& pending_days.size() != 0) begin
					push <= 1'b1;
					day_return <= pending_days[0].ret;
					missing <= pending_days[0].miss;
					last <= pending_days[0].fin;
					push_gap <= gap_len();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// long receiver stall right after reset so the block fills up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_left <= 400;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		dd_report_t exp_r;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result word");
					fail_count++;
				end else begin
					exp_r = expected_reports.pop_front();
					if (max_drawdown !== exp_r.dd) begin
						$error("max_drawdown expected %0h got %0h", exp_r.dd, max_drawdown);
						fail_count++;
					end
					if (trough_day !== exp_r.trough) begin
						$error("trough_day expected %0d got %0d", exp_r.trough, trough_day);
						fail_count++;
					end
					if (recovery_days !== exp_r.rec_days) begin
						$error("recovery_days expected %0d got %0d", exp_r.rec_days,
							recovery_days);
						fail_count++;
					end
					if (recovered !== exp_r.rec) begin
						$error("recovered expected %0b got %0b", exp_r.rec, recovered);
						fail_count++;
					end
					if (all_missing !== exp_r.all_miss) begin
						$error("all_missing expected %0b got %0b", exp_r.all_miss,
							all_missing);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				pop <= 1'b0;
			end else if ($urandom_range(0, 9) < 3) begin
				hold_off <= gap_len();
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 900000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int len;
		clear_series();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed series
		add_day(32'h0000_0000, 1'b0, 1'b1);             // no drawdown
		add_day(32'h1234_5678, 1'b1, 1'b0);             // all missing
		add_day(32'hFFFF_FFFF, 1'b1, 1'b1);
		add_day(32'h7FFF_FFFF, 1'b0, 1'b0);             // max rise, then wipe out
		add_day(32'h8000_0000, 1'b0, 1'b0);
		add_day(32'h0100_0000, 1'b0, 1'b1);
		add_day(32'h0800_0000, 1'b0, 1'b0);             // dip, gap, recovery
		add_day(32'hF800_0000, 1'b0, 1'b0);
		add_day(32'h0000_0000, 1'b1, 1'b0);
		add_day(32'h0000_0000, 1'b1, 1'b0);
		add_day(32'h1000_0000, 1'b0, 1'b0);
		add_day(32'h0000_0000, 1'b1, 1'b1);             // trailing missing last
		add_day(32'hF000_0000, 1'b0, 1'b0);             // factor exactly zero
		add_day(32'h0000_0000, 1'b0, 1'b1);
		add_day(32'hFFFF_FFFF, 1'b0, 1'b0);             // tiny drop, truncates
		add_day(32'h0000_0001, 1'b0, 1'b1);
		for (int i = 0; i < 8; i++)
			add_day(32'h7FFF_FFFF, 1'b0, 1'b0);         // saturate value
		add_day(32'hFFFF_0000, 1'b0, 1'b1);

		// pressure: many short series go in while the receiver is held off
		for (int i = 0; i < 20; i++)
			add_day(rand_return(), 1'b0, 1'b1);

		n = 0;
		while (n < 1700) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 25);
			for (int i = 0; i < len; i++) begin
				add_day(rand_return(), $urandom_range(0, 9) < 2, i == len - 1);
				n++;
			end
		end

		wait (pending_days.size() == 0);
		@(posedge clk);
		wait (expected_reports.size() == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[max_drawdown_tracker_unit.f]
+incdir+rtl
rtl/mdt_pkg.sv
rtl/mdt_front.sv
rtl/mdt_back.sv
rtl/max_drawdown_tracker_unit.sv
tb/tb_max_drawdown_tracker_unit.sv
